>>> hdl/packed_index_unpacker_macros.svh
// Assertion macros used by the packed index unpacker datapath.
// Depends on nothing; included by pidx_datapath, the module that carries assertions.
`ifndef PACKED_INDEX_UNPACKER_MACROS_SVH
`define PACKED_INDEX_UNPACKER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDX_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

>>> hdl/pidx_pkg.sv
// Shared constants, types, codes and helper functions of the packed index unpacker.
// Depends on nothing; used by pidx_ctrl, pidx_datapath and packed_index_unpacker.
`timescale 1ns / 1ps

package pidx_pkg;

    localparam int MAX_EDGE      = 256;
    localparam int PALETTE_DEPTH = 4096;
    localparam int WORD_W        = 64;
    localparam int ID_W_MIN      = 2;
    localparam int ID_W_MAX      = 12;
    localparam int COORD_W       = $clog2(MAX_EDGE);
    localparam int SIZE_W        = 9;
    localparam int PCOUNT_W      = 13;
    localparam int TBL_AW        = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W       = 8;
    localparam int BUF_W         = WORD_W + ID_W_MAX;
    localparam int REM_W         = $clog2(BUF_W + 1);
    localparam int RCNT_W        = 4;
    localparam int IDW_W         = $clog2(ID_W_MAX + 1);
    localparam int CFG_IDX_W     = 2;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [SIZE_W-1:0]   size_t;
    typedef logic [PCOUNT_W-1:0] pcount_t;
    typedef logic [TBL_AW-1:0]   tbl_addr_t;
    typedef logic [COLOR_W-1:0]  color_t;
    typedef logic [BUF_W-1:0]    buf_t;
    typedef logic [REM_W-1:0]    rem_t;
    typedef logic [RCNT_W-1:0]   rcnt_t;
    typedef logic [IDW_W-1:0]    idw_t;
    typedef logic [ID_W_MAX-1:0] id_t;
    typedef logic [1:0]          kind_t;
    typedef logic [1:0]          status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Request kinds
    localparam kind_t KIND_LOAD  = 2'd0;
    localparam kind_t KIND_DATA  = 2'd1;
    localparam kind_t KIND_START = 2'd2;

    // Result status codes
    localparam status_t ST_VOXEL  = 2'd0;
    localparam status_t ST_SHORT  = 2'd1;
    localparam status_t ST_BEYOND = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t CFG_SIZE_X = 2'd0;
    localparam cfg_idx_t CFG_SIZE_Y = 2'd1;
    localparam cfg_idx_t CFG_SIZE_Z = 2'd2;
    localparam cfg_idx_t CFG_PCOUNT = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic tbl_wr;
        logic restart;
        logic load;
        logic adv;
        logic step;
        logic close;
        logic push_short;
        logic push_last;
    } pidx_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic complete;
        logic more;
        logic s2_valid;
        logic p_valid;
        logic short_pend;
        logic o_free;
    } pidx_stat_t;

    // Zero reads as one, anything past the edge limit clamps to it.
    function automatic size_t eff_size(input size_t s);
        size_t r;
        if (s == '0)
            r = size_t'(1);
        else if (s > size_t'(MAX_EDGE))
            r = size_t'(MAX_EDGE);
        else
            r = s;
        return r;
    endfunction

    // Smallest width that covers the palette, clamped to [ID_W_MIN, ID_W_MAX].
    function automatic idw_t id_width(input pcount_t pc);
        idw_t w;
        w = idw_t'(ID_W_MAX);
        for (int i = ID_W_MAX - 1; i >= ID_W_MIN; i--)
        begin
            if (32'(pc) <= (32'd1 << i))
                w = idw_t'(i);
        end
        return w;
    endfunction

    function automatic id_t id_mask(input idw_t w);
        id_t ones;
        ones = '1;
        return ones >> (idw_t'(ID_W_MAX) - w);
    endfunction

endpackage

>>> hdl/pidx_ctrl.sv
// Sequencing state machine of the packed index unpacker.
// Depends on pidx_pkg; drives pidx_datapath through pidx_cmd_t.
`timescale 1ns / 1ps

module pidx_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  pidx_pkg::kind_t        kind,
    output logic                   in_stall,
    input  pidx_pkg::pidx_stat_t   stat,
    output pidx_pkg::pidx_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UNPACK = 3'd1;
    localparam logic [2:0] S_DRAIN  = 3'd2;
    localparam logic [2:0] S_TAIL   = 3'd3;
    localparam logic [2:0] S_LAST   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (kind)
                        pidx_pkg::KIND_LOAD:  cmd.tbl_wr  = 1'b1;
                        pidx_pkg::KIND_START: cmd.restart = 1'b1;
                        pidx_pkg::KIND_DATA:
                        begin
                            if (!stat.complete)
                            begin
                                cmd.load   = 1'b1;
                                state_next = S_UNPACK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UNPACK:
            begin
                cmd.adv  = stat.o_free;
                cmd.step = stat.o_free && stat.more;
                if (!stat.more)
                begin
                    cmd.close  = 1'b1;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (stat.s2_valid)
                    cmd.adv = stat.o_free;
                else
                    state_next = S_TAIL;
            end
            S_TAIL:
            begin
                if (!stat.short_pend)
                    state_next = S_LAST;
                else if (stat.o_free)
                begin
                    cmd.push_short = 1'b1;
                    state_next     = S_LAST;
                end
            end
            S_LAST:
            begin
                if (!stat.p_valid)
                    state_next = S_IDLE;
                else if (stat.o_free)
                begin
                    cmd.push_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hdl/pidx_datapath.sv
// Datapath of the packed index unpacker: registers, bit buffer, cursors, color table,
// and the result pipeline. Depends on pidx_pkg and packed_index_unpacker_macros.svh.
`timescale 1ns / 1ps
`include "packed_index_unpacker_macros.svh"

module pidx_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pidx_pkg::pidx_cmd_t       cmd,
    output pidx_pkg::pidx_stat_t      stat,
    input  logic                      cfg_wr,
    input  pidx_pkg::cfg_idx_t        cfg_index,
    input  pidx_pkg::pcount_t         cfg_data,
    input  logic [pidx_pkg::WORD_W-1:0] packed_word,
    input  logic                      final_word,
    input  pidx_pkg::tbl_addr_t       entry_index,
    input  pidx_pkg::color_t          entry_color,
    input  logic                      out_stall,
    output logic                      out_valid,
    output pidx_pkg::coord_t          pos_x,
    output pidx_pkg::coord_t          pos_y,
    output pidx_pkg::coord_t          pos_z,
    output pidx_pkg::color_t          voxel_color,
    output pidx_pkg::status_t         status,
    output logic                      last_of_run
);

    // configuration
    pidx_pkg::size_t   size_x_reg, size_y_reg, size_z_reg;
    pidx_pkg::pcount_t pcount_reg;

    // unpack state
    pidx_pkg::buf_t    buf_reg;
    pidx_pkg::rem_t    rem_reg;
    pidx_pkg::idw_t    w_reg;
    logic              fin_reg;
    pidx_pkg::id_t     residue_bits_reg;
    pidx_pkg::rcnt_t   residue_cnt_reg;
    pidx_pkg::coord_t  cur_x_reg, cur_y_reg, cur_z_reg;
    logic              complete_reg;
    logic              short_pend_reg;

    // color table
    pidx_pkg::color_t  tbl_mem [pidx_pkg::PALETTE_DEPTH];
    pidx_pkg::color_t  mem_q_reg;

    // result pipeline: S2 -> pending -> output
    logic              s2_valid_reg;
    pidx_pkg::coord_t  s2_x_reg, s2_y_reg, s2_z_reg;
    logic              s2_beyond_reg;
    logic              p_valid_reg;
    pidx_pkg::coord_t  p_x_reg, p_y_reg, p_z_reg;
    pidx_pkg::color_t  p_color_reg;
    pidx_pkg::status_t p_status_reg;
    logic              o_valid_reg;
    pidx_pkg::coord_t  o_x_reg, o_y_reg, o_z_reg;
    pidx_pkg::color_t  o_color_reg;
    pidx_pkg::status_t o_status_reg;
    logic              o_last_reg;

    // combinational
    pidx_pkg::id_t     cur_id;
    logic              more;
    logic              o_free;
    logic              o_load;
    pidx_pkg::buf_t    buf_load;
    pidx_pkg::rem_t    rem_load;
    pidx_pkg::size_t   ex, ey, ez;
    pidx_pkg::size_t   x1, y1, z1;
    pidx_pkg::coord_t  cx_next, cy_next, cz_next;
    logic              wrap;

    assign cur_id   = buf_reg[pidx_pkg::ID_W_MAX-1:0] & pidx_pkg::id_mask(w_reg);
    assign more     = !complete_reg && (rem_reg >= pidx_pkg::rem_t'(w_reg));
    assign o_free   = !o_valid_reg || !out_stall;
    assign buf_load = (pidx_pkg::buf_t'(packed_word) << residue_cnt_reg)
                    | pidx_pkg::buf_t'(residue_bits_reg);
    assign rem_load = pidx_pkg::rem_t'(pidx_pkg::WORD_W) + pidx_pkg::rem_t'(residue_cnt_reg);
    assign o_load   = (cmd.adv && s2_valid_reg && p_valid_reg)
                    || (cmd.push_short && p_valid_reg) || cmd.push_last;

    assign stat.complete   = complete_reg;
    assign stat.more       = more;
    assign stat.s2_valid   = s2_valid_reg;
    assign stat.p_valid    = p_valid_reg;
    assign stat.short_pend = short_pend_reg;
    assign stat.o_free     = o_free;

    // Cursor walk: x fastest, then z, then y.
    assign ex = pidx_pkg::eff_size(size_x_reg);
    assign ey = pidx_pkg::eff_size(size_y_reg);
    assign ez = pidx_pkg::eff_size(size_z_reg);
    assign x1 = pidx_pkg::size_t'(cur_x_reg) + pidx_pkg::size_t'(1);
    assign y1 = pidx_pkg::size_t'(cur_y_reg) + pidx_pkg::size_t'(1);
    assign z1 = pidx_pkg::size_t'(cur_z_reg) + pidx_pkg::size_t'(1);

    always_comb
    begin
        cx_next = cur_x_reg;
        cy_next = cur_y_reg;
        cz_next = cur_z_reg;
        wrap    = 1'b0;
        if (x1 >= ex)
        begin
            cx_next = '0;
            if (z1 >= ez)
            begin
                cz_next = '0;
                if (y1 >= ey)
                begin
                    cy_next = '0;
                    wrap    = 1'b1;
                end
                else
                    cy_next = y1[pidx_pkg::COORD_W-1:0];
            end
            else
                cz_next = z1[pidx_pkg::COORD_W-1:0];
        end
        else
            cx_next = x1[pidx_pkg::COORD_W-1:0];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg <= pidx_pkg::size_t'(1);
            size_y_reg <= pidx_pkg::size_t'(1);
            size_z_reg <= pidx_pkg::size_t'(1);
            pcount_reg <= pidx_pkg::pcount_t'(1);
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                pidx_pkg::CFG_SIZE_X: size_x_reg <= pidx_pkg::size_t'(cfg_data);
                pidx_pkg::CFG_SIZE_Y: size_y_reg <= pidx_pkg::size_t'(cfg_data);
                pidx_pkg::CFG_SIZE_Z: size_z_reg <= pidx_pkg::size_t'(cfg_data);
                pidx_pkg::CFG_PCOUNT: pcount_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg          <= '0;
            w_reg            <= pidx_pkg::idw_t'(pidx_pkg::ID_W_MIN);
            fin_reg          <= 1'b0;
            residue_bits_reg <= '0;
            residue_cnt_reg  <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            cur_z_reg        <= '0;
            complete_reg     <= 1'b0;
            short_pend_reg   <= 1'b0;
            s2_valid_reg     <= 1'b0;
            p_valid_reg      <= 1'b0;
            o_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.restart)
            begin
                residue_bits_reg <= '0;
                residue_cnt_reg  <= '0;
                cur_x_reg        <= '0;
                cur_y_reg        <= '0;
                cur_z_reg        <= '0;
                complete_reg     <= 1'b0;
                short_pend_reg   <= 1'b0;
            end
            if (cmd.load)
            begin
                rem_reg <= rem_load;
                w_reg   <= pidx_pkg::id_width(pcount_reg);
                fin_reg <= final_word;
            end
            if (cmd.step)
            begin
                rem_reg   <= rem_reg - pidx_pkg::rem_t'(w_reg);
                cur_x_reg <= cx_next;
                cur_y_reg <= cy_next;
                cur_z_reg <= cz_next;
                if (wrap)
                    complete_reg <= 1'b1;
            end
            if (cmd.close)
            begin
                // keep leftover bits only if the region goes on
                if (complete_reg || fin_reg)
                begin
                    residue_bits_reg <= '0;
                    residue_cnt_reg  <= '0;
                end
                else
                begin
                    residue_bits_reg <= buf_reg[pidx_pkg::ID_W_MAX-1:0];
                    residue_cnt_reg  <= rem_reg[pidx_pkg::RCNT_W-1:0];
                end
                if (!complete_reg && fin_reg)
                begin
                    complete_reg   <= 1'b1;
                    short_pend_reg <= 1'b1;
                end
            end
            if (cmd.push_short)
                short_pend_reg <= 1'b0;

            if (cmd.adv)
                s2_valid_reg <= cmd.step && (cur_id != '0);

            if (cmd.adv && s2_valid_reg)
                p_valid_reg <= 1'b1;
            else if (cmd.push_short)
                p_valid_reg <= 1'b1;
            else if (cmd.push_last)
                p_valid_reg <= 1'b0;

            if (o_load)
                o_valid_reg <= 1'b1;
            else if (!out_stall)
                o_valid_reg <= 1'b0;
        end
    end

    // color table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.tbl_wr)
            tbl_mem[entry_index] <= entry_color;
        if (cmd.step)
            mem_q_reg <= tbl_mem[cur_id];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            buf_reg <= buf_load;
        else if (cmd.step)
            buf_reg <= buf_reg >> w_reg;

        if (cmd.adv)
        begin
            s2_x_reg      <= cur_x_reg;
            s2_y_reg      <= cur_y_reg;
            s2_z_reg      <= cur_z_reg;
            s2_beyond_reg <= pidx_pkg::pcount_t'(cur_id) >= pcount_reg;
        end

        if (cmd.adv && s2_valid_reg)
        begin
            p_x_reg      <= s2_x_reg;
            p_y_reg      <= s2_y_reg;
            p_z_reg      <= s2_z_reg;
            p_color_reg  <= s2_beyond_reg ? '0 : mem_q_reg;
            p_status_reg <= s2_beyond_reg ? pidx_pkg::ST_BEYOND : pidx_pkg::ST_VOXEL;
        end
        else if (cmd.push_short)
        begin
            p_x_reg      <= cur_x_reg;
            p_y_reg      <= cur_y_reg;
            p_z_reg      <= cur_z_reg;
            p_color_reg  <= '0;
            p_status_reg <= pidx_pkg::ST_SHORT;
        end

        if (o_load)
        begin
            o_x_reg      <= p_x_reg;
            o_y_reg      <= p_y_reg;
            o_z_reg      <= p_z_reg;
            o_color_reg  <= p_color_reg;
            o_status_reg <= p_status_reg;
            o_last_reg   <= cmd.push_last;
        end
    end

    assign out_valid   = o_valid_reg;
    assign pos_x       = o_x_reg;
    assign pos_y       = o_y_reg;
    assign pos_z       = o_z_reg;
    assign voxel_color = o_color_reg;
    assign status      = o_status_reg;
    assign last_of_run = o_last_reg;

    `PIDX_ASSERT_IMP(a_last_into_free_slot, clk, rst_n, cmd.push_last, o_free)
    `PIDX_ASSERT_IMP(a_short_marks_done, clk, rst_n, cmd.push_short, short_pend_reg && complete_reg)
    `PIDX_ASSERT_NXT(a_load_fills_word, clk, rst_n, cmd.load, rem_reg >= pidx_pkg::rem_t'(pidx_pkg::WORD_W))
    `PIDX_ASSERT_IMP(a_residue_narrow, clk, rst_n, 1'b1, residue_cnt_reg < pidx_pkg::rcnt_t'(pidx_pkg::ID_W_MAX))

endmodule

>>> hdl/packed_index_unpacker.sv
// Top level of the packed index unpacker: joins the controller and the datapath.
// Depends on pidx_pkg, pidx_ctrl and pidx_datapath.
//
//   channel   direction   handshake            carries
//   cfg       in          cfg_valid/cfg_ready  cfg_index, cfg_data (register write)
//   in        in          in_valid/in_stall    kind, packed_word, final_word,
//                                              entry_index, entry_color
//   out       out         out_valid/out_stall  pos_x/y/z, voxel_color, status,
//                                              last_of_run
//
// Table loads, region starts and ignored requests are taken in the idle state. A
// data word is accepted, then its ids are extracted one id per cycle through the
// bit buffer, followed by close, drain, tail and last-result steps.
// The id walk is set by the single extract-and-shift unit and the one read port
// of the color table. Reset clears cursors, residue and region flags and sets
// all sizes and the palette count to 1; the color table is not cleared.
// A stalled output holds the whole result pipeline and so the id walk.
`timescale 1ns / 1ps

module packed_index_unpacker
(
    input  logic                        clk,
    input  logic                        rst_n,

    // configuration writes, always ready
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  pidx_pkg::cfg_idx_t          cfg_index,
    input  pidx_pkg::pcount_t           cfg_data,

    // request channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  pidx_pkg::kind_t             kind,
    input  logic [pidx_pkg::WORD_W-1:0] packed_word,
    input  logic                        final_word,
    input  pidx_pkg::tbl_addr_t         entry_index,
    input  pidx_pkg::color_t            entry_color,

    // result channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output pidx_pkg::coord_t            pos_x,
    output pidx_pkg::coord_t            pos_y,
    output pidx_pkg::coord_t            pos_z,
    output pidx_pkg::color_t            voxel_color,
    output pidx_pkg::status_t           status,
    output logic                        last_of_run
);

    pidx_pkg::pidx_cmd_t  cmd;
    pidx_pkg::pidx_stat_t stat;
    logic                 cfg_wr;

    // The user must only change configuration while idle; it is not enforced.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // Controller: accept one request at a time, sequence the id walk and
    // the hand-off of the last result of each request.
    pidx_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: hold the residue and cursors, extract ids, look up colors,
    // and advance results through pending and output registers.
    pidx_datapath u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr      (cfg_wr),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .packed_word (packed_word),
        .final_word  (final_word),
        .entry_index (entry_index),
        .entry_color (entry_color),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .voxel_color (voxel_color),
        .status      (status),
        .last_of_run (last_of_run)
    );

endmodule

>>> sim/packed_index_unpacker_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for packed_index_unpacker: directed and random requests,
// a voxel predictor class that checks every result. Depends on pidx_pkg and the RTL.

import pidx_pkg::*;

typedef struct packed {
    kind_t       kind;
    logic [63:0] word;
    logic        fin;
    tbl_addr_t   idx;
    color_t      color;
} unpack_req_t;

typedef struct packed {
    coord_t  x;
    coord_t  y;
    coord_t  z;
    color_t  color;
    status_t st;
    logic    last;
} voxel_result_t;

// Tracks the unpacker state, predicts the voxels of each accepted request and
// matches them against the output channel in order.
class voxel_predictor;
    color_t          color_tbl [PALETTE_DEPTH];
    bit              loaded [PALETTE_DEPTH];
    int unsigned     loaded_ids [$];
    int unsigned     res_bits, res_cnt;
    int unsigned     cur_x, cur_y, cur_z;
    bit              complete;
    int unsigned     span_x, span_y, span_z, pcount;
    voxel_result_t   batch [$];
    voxel_result_t   expected_voxels [$];
    int unsigned     mismatches;

    function new();
        res_bits   = 0;
        res_cnt    = 0;
        cur_x      = 0;
        cur_y      = 0;
        cur_z      = 0;
        complete   = 1'b0;
        span_x     = 1;
        span_y     = 1;
        span_z     = 1;
        pcount     = 1;
        mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, int unsigned value);
        case (idx)
            CFG_SIZE_X: span_x = value & 'h1FF;
            CFG_SIZE_Y: span_y = value & 'h1FF;
            CFG_SIZE_Z: span_z = value & 'h1FF;
            CFG_PCOUNT: pcount = value & 'h1FFF;
            default: ;
        endcase
    endfunction

    function int unsigned clip_span(int unsigned s);
        if (s == 0)
            return 1;
        if (s > MAX_EDGE)
            return MAX_EDGE;
        return s;
    endfunction

    function int unsigned id_bits();
        int unsigned w;
        w = 0;
        while (w < ID_W_MAX && pcount > (32'd1 << w))
            w++;
        if (w < ID_W_MIN)
            w = ID_W_MIN;
        return w;
    endfunction

    // Air, flagged ids and loaded entries never touch an unwritten table slot.
    function bit is_safe(int unsigned id);
        return id == 0 || id >= pcount || loaded[id];
    endfunction

    function void step_cursor();
        cur_x++;
        if (cur_x >= clip_span(span_x))
        begin
            cur_x = 0;
            cur_z++;
            if (cur_z >= clip_span(span_z))
            begin
                cur_z = 0;
                cur_y++;
                if (cur_y >= clip_span(span_y))
                begin
                    cur_y    = 0;
                    complete = 1'b1;
                end
            end
        end
    endfunction

    function void record(status_t st, color_t c);
        voxel_result_t v;
        v.x     = coord_t'(cur_x);
        v.y     = coord_t'(cur_y);
        v.z     = coord_t'(cur_z);
        v.color = c;
        v.st    = st;
        v.last  = 1'b0;
        batch.push_back(v);
    endfunction

    function void absorb_request(unpack_req_t r);
        int unsigned  w, total, p, id, left;
        logic [127:0] bitbuf, mask;
        batch.delete();
        case (r.kind)
            KIND_LOAD:
            begin
                color_tbl[r.idx] = r.color;
                if (!loaded[r.idx])
                begin
                    loaded[r.idx] = 1'b1;
                    loaded_ids.push_back(r.idx);
                end
            end
            KIND_START:
            begin
                res_bits = 0;
                res_cnt  = 0;
                cur_x    = 0;
                cur_y    = 0;
                cur_z    = 0;
                complete = 1'b0;
            end
            KIND_DATA:
            begin
                if (!complete)
                begin
                    w      = id_bits();
                    bitbuf = (128'(r.word) << res_cnt) | 128'(res_bits);
                    total  = res_cnt + 64;
                    p      = 0;
                    mask   = (128'd1 << w) - 1;
                    while (!complete && p + w <= total)
                    begin
                        id = int'((bitbuf >> p) & mask);
                        p += w;
                        if (id != 0)
                        begin
                            if (id >= pcount)
                                record(ST_BEYOND, '0);
                            else
                                record(ST_VOXEL, color_tbl[id]);
                        end
                        step_cursor();
                    end
                    if (complete)
                    begin
                        res_bits = 0;
                        res_cnt  = 0;
                    end
                    else
                    begin
                        left     = total - p;
                        res_cnt  = left;
                        res_bits = int'((bitbuf >> p) & ((128'd1 << left) - 1));
                        if (r.fin)
                        begin
                            record(ST_SHORT, '0);
                            complete = 1'b1;
                            res_bits = 0;
                            res_cnt  = 0;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_voxels.push_back(batch[i]);
    endfunction

    function void flag(string what, voxel_result_t want, voxel_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected (%0d,%0d,%0d) color %0d status %0d last %0d, %s",
                     what, want.x, want.y, want.z, want.color, want.st, want.last,
                     $sformatf("got (%0d,%0d,%0d) color %0d status %0d last %0d",
                               got.x, got.y, got.z, got.color, got.st, got.last));
    endfunction

    function void match_voxel(voxel_result_t got);
        voxel_result_t want;
        if (expected_voxels.size() == 0)
        begin
            flag("result with nothing pending", '0, got);
            return;
        end
        want = expected_voxels.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.color !== want.color || got.st !== want.st || got.last !== want.last)
            flag("voxel mismatch", want, got);
    endfunction

    function int unsigned pending();
        return expected_voxels.size();
    endfunction

    function void close_out();
        if (expected_voxels.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_voxels.size());
            mismatches += expected_voxels.size();
        end
    endfunction
endclass

module packed_index_unpacker_tb;

    localparam int    WATCHDOG_LIMIT  = 4000;
    // longest stretch a word with only air may keep the block busy, with margin
    localparam int    SETTLE_CYCLES   = 48;
    localparam int    RANDOM_REQUESTS = 390;
    localparam kind_t KIND_UNUSED     = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n;

    logic                 cfg_valid;
    logic                 cfg_ready;
    cfg_idx_t             cfg_index;
    pcount_t              cfg_data;

    logic                 in_valid;
    logic                 in_stall;
    kind_t                kind;
    logic [WORD_W-1:0]    packed_word;
    logic                 final_word;
    tbl_addr_t            entry_index;
    color_t               entry_color;

    logic                 out_valid;
    logic                 out_stall;
    coord_t               pos_x;
    coord_t               pos_y;
    coord_t               pos_z;
    color_t               voxel_color;
    status_t              status;
    logic                 last_of_run;

    voxel_predictor       oracle;
    bit                   calm = 1'b0;     // phase without any idling on either side
    int unsigned          idle_cycles = 0;

    packed_index_unpacker dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .packed_word (packed_word),
        .final_word  (final_word),
        .entry_index (entry_index),
        .entry_color (entry_color),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .voxel_color (voxel_color),
        .status      (status),
        .last_of_run (last_of_run)
    );

    always #2 clk = ~clk;

    // Idle cycles before the next request or between results; none in a calm phase.
    function automatic int unsigned draw_gap();
        return calm ? 0 : $urandom_range(8, 0);
    endfunction

    // Choose one id of width w: air, an id beyond the palette, or a loaded entry.
    function automatic int unsigned pick_id(int unsigned w);
        int unsigned max_id, roll, cand;
        max_id = (32'd1 << w) - 1;
        roll   = $urandom_range(99, 0);
        if (roll < 25)
            return 0;
        if (roll < 45 && oracle.pcount <= max_id)
            return $urandom_range(max_id, oracle.pcount);
        for (int k = 0; k < 8 && oracle.loaded_ids.size() > 0; k++)
        begin
            cand = oracle.loaded_ids[$urandom_range(oracle.loaded_ids.size() - 1, 0)];
            if (cand != 0 && cand < oracle.pcount && cand <= max_id)
                return cand;
        end
        if (oracle.pcount <= max_id)
            return $urandom_range(max_id, oracle.pcount);
        return 0;
    endfunction

    function automatic unpack_req_t data_req(logic [63:0] word, logic fin);
        unpack_req_t r;
        r.kind  = KIND_DATA;
        r.word  = word;
        r.fin   = fin;
        r.idx   = tbl_addr_t'($urandom);
        r.color = color_t'($urandom);
        return r;
    endfunction

    function automatic unpack_req_t load_req(int unsigned idx, int unsigned color);
        unpack_req_t r;
        r.kind  = KIND_LOAD;
        r.word  = {$urandom, $urandom};
        r.fin   = 1'($urandom);
        r.idx   = tbl_addr_t'(idx);
        r.color = color_t'(color);
        return r;
    endfunction

    function automatic unpack_req_t start_req();
        unpack_req_t r;
        r       = data_req({$urandom, $urandom}, 1'($urandom));
        r.kind  = KIND_START;
        return r;
    endfunction

    function automatic unpack_req_t stray_req();
        unpack_req_t r;
        r       = data_req({$urandom, $urandom}, 1'($urandom));
        r.kind  = KIND_UNUSED;
        return r;
    endfunction

    // Build a data word that continues the current bit stream: finish the id that
    // spans in from the residue, fill whole ids, and start a safe id in the tail.
    function automatic unpack_req_t fresh_word(logic fin);
        logic [63:0] word;
        int unsigned w, rc, pos, hi_w, span_n, start, cand, h;
        bit          found;
        w     = oracle.id_bits();
        rc    = oracle.res_cnt;
        word  = '0;
        pos   = 0;
        found = 1'b0;
        h     = 0;
        if (rc > 0 && rc < w)
        begin
            hi_w   = w - rc;
            span_n = 32'd1 << hi_w;
            start  = $urandom_range(span_n - 1, 0);
            for (int k = 0; k < span_n; k++)
            begin
                cand = (start + k) % span_n;
                if (!found && oracle.is_safe(oracle.res_bits | (cand << rc)))
                begin
                    h     = cand;
                    found = 1'b1;
                end
            end
            word = 64'(h);
            pos  = hi_w;
        end
        while (pos + w <= 64)
        begin
            word |= 64'(pick_id(w)) << pos;
            pos  += w;
        end
        if (pos < 64)
            word |= 64'(pick_id(w)) << pos;
        return data_req(word, fin);
    endfunction

    // Present one request at a falling edge, hold it until the block takes it.
    task automatic send_request(unpack_req_t r);
        int unsigned gap;
        gap = draw_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        kind        <= r.kind;
        packed_word <= r.word;
        final_word  <= r.fin;
        entry_index <= r.idx;
        entry_color <= r.color;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        oracle.absorb_request(r);
    endtask

    task automatic write_reg(cfg_idx_t idx, int unsigned value);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data  <= pcount_t'(value);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        oracle.set_reg(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, drain every pending result, then give an air-only word time to finish.
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (oracle.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Result side: check each accepted result, then hold stall for a drawn gap.
    initial
    begin
        int unsigned   hold;
        voxel_result_t got;
        out_stall = 1'b0;
        hold      = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                got.x     = pos_x;
                got.y     = pos_y;
                got.z     = pos_z;
                got.color = voxel_color;
                got.st    = status;
                got.last  = last_of_run;
                oracle.match_voxel(got);
                hold = draw_gap();
            end
            @(negedge clk);
            out_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    // Count cycles with no handshake on any channel; a hung block ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int unsigned sent, roll, pc, cap, n_items, axis;
        int unsigned dims [3];
        logic [63:0] wide_ids;
        unpack_req_t r;

        oracle      = new();
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_SIZE_X;
        cfg_data    = '0;
        in_valid    = 1'b0;
        kind        = KIND_LOAD;
        packed_word = '0;
        final_word  = 1'b0;
        entry_index = '0;
        entry_color = '0;
        sent        = 0;
        wide_ids    = {4'h0, {5{12'hFFF}}};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: 8x2x3 region, 2-bit ids, id 3 lies beyond a palette of three.
        write_reg(CFG_SIZE_X, 8);
        write_reg(CFG_SIZE_Y, 2);
        write_reg(CFG_SIZE_Z, 3);
        write_reg(CFG_PCOUNT, 3);
        send_request(load_req(1, 8'h00));
        send_request(load_req(2, 8'hFF));
        send_request(load_req(3, 8'h5A));
        send_request(load_req(4095, 8'hC3));
        // ids 0,1,2,3 repeated: air skipped, id 3 flagged
        send_request(data_req(64'hE4E4_E4E4_E4E4_E4E4, 1'b0));
        // completes the region mid-word; the rest of the word is dropped
        send_request(data_req('1, 1'b0));
        // region complete: data words and the unused kind are ignored
        send_request(data_req({$urandom, $urandom}, 1'b1));
        send_request(stray_req());
        // full word of voxels on a final word: 32 results and a short flag
        send_request(start_req());
        send_request(data_req(64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
        // only air, then final: the short flag alone
        send_request(start_req());
        send_request(data_req('0, 1'b1));
        settle();

        // Extremes: zero size acts as one, oversize clamps, palette count zero.
        write_reg(CFG_SIZE_X, 0);
        write_reg(CFG_SIZE_Y, 511);
        write_reg(CFG_SIZE_Z, 13'h1000);
        write_reg(CFG_PCOUNT, 0);
        send_request(start_req());
        send_request(fresh_word(1'b0));
        settle();
        // widest ids mid-region, residue left behind, then run short
        write_reg(CFG_PCOUNT, 8191);
        send_request(data_req(wide_ids, 1'b0));
        send_request(fresh_word(1'b1));
        settle();
        write_reg(CFG_PCOUNT, 4096);
        send_request(start_req());
        send_request(data_req(wide_ids, 1'b0));
        send_request(fresh_word(1'b1));

        // Random phases: new settings, some table loads, then a burst of requests.
        while (sent < RANDOM_REQUESTS)
        begin
            settle();
            // config changes mid-region only on an id boundary
            if (oracle.res_cnt != 0)
            begin
                send_request(start_req());
                settle();
            end
            calm = ($urandom_range(3, 0) == 0);

            if ($urandom_range(9, 0) == 0)
            begin
                // one long axis, the others thin
                foreach (dims[i])
                    dims[i] = $urandom_range(2, 0);
                axis       = $urandom_range(2, 0);
                dims[axis] = $urandom_range(1, 0) ? 256 : 511;
            end
            else
            begin
                foreach (dims[i])
                    dims[i] = $urandom_range(6, 1);
            end

            roll = $urandom_range(9, 0);
            case (roll)
                0:       pc = 0;
                1:       pc = 1;
                2:       pc = 4096;
                3:       pc = 8191;
                4:       pc = 32'd1 << $urandom_range(12, 1);
                5, 6:    pc = $urandom_range(4096, 2);
                default: pc = $urandom_range(20, 2);
            endcase

            // upper bits of a size write fall outside the register
            write_reg(CFG_SIZE_X, dims[0] | ($urandom_range(15, 0) << 9));
            write_reg(CFG_SIZE_Y, dims[1] | ($urandom_range(15, 0) << 9));
            write_reg(CFG_SIZE_Z, dims[2] | ($urandom_range(15, 0) << 9));
            write_reg(CFG_PCOUNT, pc);

            if ($urandom_range(1, 0))
            begin
                send_request(start_req());
                sent++;
            end

            cap = (pc > PALETTE_DEPTH) ? PALETTE_DEPTH - 1 : pc - 1;
            repeat ($urandom_range(6, 2))
            begin
                if (pc >= 2)
                    send_request(load_req($urandom_range(cap, 1), $urandom_range(255, 0)));
                else
                    send_request(load_req($urandom_range(4095, 0), $urandom_range(255, 0)));
                sent++;
            end

            n_items = $urandom_range(30, 10);
            repeat (n_items)
            begin
                roll = $urandom_range(99, 0);
                if (oracle.complete)
                begin
                    if (roll < 60)
                        r = start_req();
                    else if (roll < 80)
                        r = data_req({$urandom, $urandom}, 1'($urandom));
                    else if (roll < 90)
                        r = stray_req();
                    else
                        r = load_req($urandom_range(4095, 0), $urandom_range(255, 0));
                end
                else
                begin
                    if (roll < 80)
                        r = fresh_word($urandom_range(9, 0) == 0);
                    else if (roll < 85)
                        r = start_req();
                    else if (roll < 92)
                        r = load_req($urandom_range(4095, 0), $urandom_range(255, 0));
                    else
                        r = stray_req();
                end
                send_request(r);
                sent++;
            end
        end

        settle();
        oracle.close_out();
        if (oracle.mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
